// ===== hw/rtl/fpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the five-point derivative stream
// Payload structs, result codes and the stencil selector codes.
// ---------------------------------------------------------------------------
package fpd_pkg;

  // sample width of the input field
  localparam int SAMPLE_W = 24;
  // scale register: signed Q8.24
  localparam int SCALE_W  = 32;
  localparam int FRAC_W   = 24;
  localparam int DERIV_W  = 32;
  // stencil sum grows by the sum of coefficient magnitudes (128) plus sign
  localparam int SUM_W    = SAMPLE_W + 8;
  localparam int PROD_W   = SUM_W + SCALE_W;
  // window depth and points per stencil
  localparam int WIN_D    = 4;
  localparam int NPTS     = WIN_D + 1;
  localparam int NOPS     = 7;

  typedef logic signed [SAMPLE_W-1:0] fpd_smp_t;
  typedef fpd_smp_t [NPTS-1:0] fpd_pts_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_ZERO  = 2'd2
  } fpd_status_t;

  // one code per result kind; also the bit position in the pending mask
  typedef enum logic [2:0] {
    OP_FWD0   = 3'd0,
    OP_FWD1   = 3'd1,
    OP_CENTER = 3'd2,
    OP_BACK1  = 3'd3,
    OP_BACK0  = 3'd4,
    OP_SHORT  = 3'd5,
    OP_ZERO   = 3'd6
  } fpd_op_t;

  typedef struct packed {
    fpd_op_t op;
    logic    eor;
  } fpd_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } fpd_in_t;

  typedef struct packed {
    logic signed [DERIV_W-1:0] derivative;
    logic [1:0]                status;
    logic                      end_of_run;
  } fpd_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fpd_window_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpd_window_cell: one tap of the sample window
// Holds one sample and takes its neighbor's value on every transfer.
// ---------------------------------------------------------------------------
module fpd_window_cell (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire fpd_pkg::fpd_smp_t d,
  output fpd_pkg::fpd_smp_t     q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fpd_issue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpd_issue: result sequencer
// Holds the five points of one item and a mask of pending results, and
// hands out one result command per cycle unless stalled, lowest code first.
// ---------------------------------------------------------------------------
module fpd_issue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic [fpd_pkg::NOPS-1:0] load_mask,
  input  wire fpd_pkg::fpd_pts_t        load_pts,
  output logic                         room,
  output logic                         cmd_valid,
  input  wire logic                    cmd_ready,
  output fpd_pkg::fpd_cmd_t             cmd,
  output fpd_pkg::fpd_pts_t             pts
);

  logic [fpd_pkg::NOPS-1:0] mask;
  logic [fpd_pkg::NOPS-1:0] mask_next;
  logic [fpd_pkg::NOPS-1:0] pick;
  logic [fpd_pkg::NOPS-1:0] rest;
  logic [2:0]               pick_code;
  logic                     fire;

  // lowest pending bit
  always_comb begin
    pick      = '0;
    pick_code = '0;
    for (int k = fpd_pkg::NOPS - 1; k >= 0; k--) begin
      if (mask[k]) begin
        pick      = '0;
        pick[k]   = 1'b1;
        pick_code = 3'(k);
      end
    end
  end

  assign rest      = mask & ~pick;
  assign cmd_valid = |mask;
  assign fire      = cmd_valid && cmd_ready;
  assign room      = !cmd_valid || (fire && (rest == '0));

  assign cmd.op  = fpd_pkg::fpd_op_t'(pick_code);
  assign cmd.eor = (cmd.op == fpd_pkg::OP_BACK0) || (cmd.op == fpd_pkg::OP_SHORT) ||
                   (cmd.op == fpd_pkg::OP_ZERO);

  always_comb begin
    mask_next = mask;
    if (load) begin
      mask_next = load_mask;
    end else if (fire) begin
      mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pts <= load_pts;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fpd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpd_datapath: stencil sum, scale multiply, round and clip
// Three register stages with per-stage flow control; the last one is the
// output register.
// ---------------------------------------------------------------------------
module fpd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_ready,
  input  wire fpd_pkg::fpd_cmd_t                    cmd,
  input  wire fpd_pkg::fpd_pts_t                    pts,
  input  wire logic signed [fpd_pkg::SCALE_W-1:0]   scale,
  output logic                                     dst_valid,
  input  wire logic                                dst_ready,
  output fpd_pkg::fpd_out_t                         dst_data
);

  localparam int SUM_W  = fpd_pkg::SUM_W;
  localparam int PROD_W = fpd_pkg::PROD_W;
  localparam int FRAC_W = fpd_pkg::FRAC_W;
  localparam int Q_W    = PROD_W - FRAC_W;
  localparam int D_W    = fpd_pkg::DERIV_W;
  localparam int EXT_W  = SUM_W - fpd_pkg::SAMPLE_W;

  localparam logic signed [SUM_W-1:0] K3  = SUM_W'(3);
  localparam logic signed [SUM_W-1:0] K6  = SUM_W'(6);
  localparam logic signed [SUM_W-1:0] K8  = SUM_W'(8);
  localparam logic signed [SUM_W-1:0] K10 = SUM_W'(10);
  localparam logic signed [SUM_W-1:0] K16 = SUM_W'(16);
  localparam logic signed [SUM_W-1:0] K18 = SUM_W'(18);
  localparam logic signed [SUM_W-1:0] K25 = SUM_W'(25);
  localparam logic signed [SUM_W-1:0] K36 = SUM_W'(36);
  localparam logic signed [SUM_W-1:0] K48 = SUM_W'(48);

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);
  localparam logic [D_W-1:0] D_MAX = {1'b0, {(D_W - 1){1'b1}}};
  localparam logic [D_W-1:0] D_MIN = {1'b1, {(D_W - 1){1'b0}}};

  logic signed [SUM_W-1:0] e [fpd_pkg::NPTS];
  logic signed [SUM_W-1:0] sum_c;
  fpd_pkg::fpd_status_t    st_c;

  logic                    v1;
  logic                    v2;
  logic                    r1;
  logic                    r2;
  logic                    r3;
  logic signed [SUM_W-1:0] sum1;
  logic [1:0]              st1;
  logic                    eor1;
  logic signed [PROD_W-1:0] prod2;
  logic [1:0]              st2;
  logic                    eor2;

  logic signed [PROD_W-1:0] rnd;
  logic [Q_W-1:0]           q;
  logic [D_W-1:0]           clip;

  always_comb begin
    for (int i = 0; i < fpd_pkg::NPTS; i++) begin
      e[i] = $signed({{EXT_W{pts[i][fpd_pkg::SAMPLE_W-1]}}, pts[i]});
    end
  end

  // stencil sums; e[0] is the oldest point, e[4] the newest
  always_comb begin
    st_c = fpd_pkg::ST_OK;
    case (cmd.op)
      fpd_pkg::OP_FWD0:
        sum_c = K48 * e[1] + K16 * e[3] - K25 * e[0] - K36 * e[2] - K3 * e[4];
      fpd_pkg::OP_FWD1:
        sum_c = K18 * e[2] + e[4] - K3 * e[0] - K10 * e[1] - K6 * e[3];
      fpd_pkg::OP_CENTER:
        sum_c = e[0] - e[4] + K8 * (e[3] - e[1]);
      fpd_pkg::OP_BACK1:
        sum_c = K6 * e[1] + K10 * e[3] + K3 * e[4] - e[0] - K18 * e[2];
      fpd_pkg::OP_BACK0:
        sum_c = K3 * e[0] + K36 * e[2] + K25 * e[4] - K16 * e[1] - K48 * e[3];
      fpd_pkg::OP_SHORT: begin
        sum_c = '0;
        st_c  = fpd_pkg::ST_SHORT;
      end
      fpd_pkg::OP_ZERO: begin
        sum_c = '0;
        st_c  = fpd_pkg::ST_ZERO;
      end
      default: sum_c = '0;
    endcase
  end

  assign r3        = !dst_valid || dst_ready;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign cmd_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= cmd_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        dst_valid <= v2;
      end
    end
  end

  // status results carry a zero sum, so they leave as derivative zero
  assign rnd = prod2 + HALF;
  assign q   = rnd[PROD_W-1:FRAC_W];

  always_comb begin
    if (!q[Q_W-1] && (|q[Q_W-2:D_W-1])) begin
      clip = D_MAX;
    end else if (q[Q_W-1] && !(&q[Q_W-2:D_W-1])) begin
      clip = D_MIN;
    end else begin
      clip = q[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      sum1 <= sum_c;
      st1  <= st_c;
      eor1 <= cmd.eor;
    end
    if (r2) begin
      prod2 <= sum1 * scale;
      st2   <= st1;
      eor2  <= eor1;
    end
    if (r3) begin
      dst_data.derivative <= $signed(clip);
      dst_data.status     <= st2;
      dst_data.end_of_run <= eor2;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/five_point_derivative_stream_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// five_point_derivative_stream_unit: streaming five-point derivative
// Degree-4 Lagrange stencils over a four-tap sample window, scaled by a
// Q8.24 register, rounded half up and clipped to 32 bits.
// ---------------------------------------------------------------------------
// Samples arrive one per transfer; a run ends with last set. Once four
// samples of a run are held, every sample yields the central-difference
// derivative of the point two back; the fifth sample also yields the two
// leading one-sided results, and the last sample the two trailing ones
// (end_of_run on the final one). A run of fewer than five samples gives a
// single short-run status result; with a zero scale, a longer run gives no
// data and one zero-step status result on its last sample. The block takes
// one sample per cycle while each sample yields at most one result and
// the result channel does not stall; a sample with more results holds
// back the next, as the sequencer hands out one result per cycle and
// takes the next sample when its last pending result leaves. The scale
// register may be written only while no results are pending.
// ---------------------------------------------------------------------------
module five_point_derivative_stream_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample channel
  input  wire logic                                src_valid,
  output logic                                     src_ready,
  input  wire fpd_pkg::fpd_in_t                     src_data,
  // result channel
  output logic                                     dst_valid,
  input  wire logic                                dst_ready,
  output fpd_pkg::fpd_out_t                         dst_data,
  // scale register write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic signed [fpd_pkg::SCALE_W-1:0]   cfg_data
);

  localparam int NOPS  = fpd_pkg::NOPS;
  localparam int WIN_D = fpd_pkg::WIN_D;

  logic signed [fpd_pkg::SCALE_W-1:0] scale;
  logic [2:0]                         count;
  logic [2:0]                         count_next;
  logic                               take;
  logic [NOPS-1:0]                    plan;
  fpd_pkg::fpd_smp_t                  win [WIN_D];
  fpd_pkg::fpd_pts_t                  pts_in;
  fpd_pkg::fpd_pts_t                  pts;
  fpd_pkg::fpd_cmd_t                  cmd;
  logic                               cmd_valid;
  logic                               cmd_ready;
  logic                               room;

  // scale register; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= '0;
    end else if (cfg_valid) begin
      scale <= cfg_data;
    end
  end

  assign src_ready = room;
  assign take      = src_valid && src_ready;

  // window: win[0] oldest, win[3] newest; shifts on every sample transfer
  for (genvar i = 0; i < WIN_D; i++) begin : g_win
    fpd_window_cell u_cell (
      .clk   (clk),
      .shift (take),
      .d     ((i == WIN_D - 1) ? src_data.sample : win[(i + 1) % WIN_D]),
      .q     (win[i])
    );
  end

  always_comb begin
    for (int i = 0; i < WIN_D; i++) begin
      pts_in[i] = win[i];
    end
    pts_in[WIN_D] = src_data.sample;
  end

  // results caused by this sample, one mask bit per result kind
  always_comb begin
    plan = '0;
    if (count < 3'(WIN_D)) begin
      plan[fpd_pkg::OP_SHORT] = src_data.last;
    end else if (scale == '0) begin
      plan[fpd_pkg::OP_ZERO] = src_data.last;
    end else begin
      plan[fpd_pkg::OP_FWD0]   = (count == 3'(WIN_D));
      plan[fpd_pkg::OP_FWD1]   = (count == 3'(WIN_D));
      plan[fpd_pkg::OP_CENTER] = 1'b1;
      plan[fpd_pkg::OP_BACK1]  = src_data.last;
      plan[fpd_pkg::OP_BACK0]  = src_data.last;
    end
  end

  // samples seen in the run, saturating one past the window depth
  always_comb begin
    count_next = count;
    if (take) begin
      if (src_data.last) begin
        count_next = '0;
      end else if (count <= 3'(WIN_D)) begin
        count_next = count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  fpd_issue u_issue (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_mask (plan),
    .load_pts  (pts_in),
    .room      (room),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pts       (pts)
  );

  fpd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pts       (pts),
    .scale     (scale),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

endmodule
`default_nettype wire
